/* design/brfe_pkg.sv */
// Shared constants, types and helpers for the byte ring FIFO frame extractor.
`timescale 1ns / 1ps
`default_nettype none
package brfe_pkg;
	localparam int DEPTH = 64;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int FILL_W = 7;
	localparam int OP_W = 3;
	localparam int BYTE_W = 8;

	localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
	localparam logic [OP_W-1:0] OP_READ_UPTO = 3'd1;
	localparam logic [OP_W-1:0] OP_READ_EXACT = 3'd2;
	localparam logic [OP_W-1:0] OP_LINE = 3'd3;
	localparam logic [OP_W-1:0] OP_RESP = 3'd4;
	localparam logic [OP_W-1:0] OP_FRAME = 3'd5;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd6;

	localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] RESP_FIRST = 8'h10;
	localparam logic [BYTE_W-1:0] RESP_SECOND = 8'h0C;
	localparam logic [BYTE_W-1:0] FRAME_START = 8'h01;
	localparam logic [BYTE_W-1:0] FRAME_END = 8'h04;

	typedef enum logic [2:0] {
		K_WRITE,
		K_READ_UPTO,
		K_READ_EXACT,
		K_LINE,
		K_RESP,
		K_FRAME,
		K_CLEAR,
		K_NONE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [BYTE_W-1:0] data;
		logic [FILL_W-1:0] count;
	} cmd_t;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == LAST_PTR) ? '0 : p + 1'b1;
	endfunction
endpackage
`default_nettype wire

/* design/brfe_front.sv */
// Request intake: decodes each request and holds it in a two-entry command queue.
`timescale 1ns / 1ps
`default_nettype none
module brfe_front
	import brfe_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [OP_W-1:0]   op,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic [FILL_W-1:0] count,
	output logic                   cmd_valid,
	input  wire logic              cmd_ready,
	output cmd_t                   cmd
);
	cmd_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] used_q;
	cmd_t dec;
	logic push;
	logic pop;

	always_comb begin
		dec.data = data_byte;
		dec.count = count;
		case (op)
			OP_WRITE: dec.kind = K_WRITE;
			OP_READ_UPTO: dec.kind = K_READ_UPTO;
			OP_READ_EXACT: dec.kind = K_READ_EXACT;
			OP_LINE: dec.kind = K_LINE;
			OP_RESP: dec.kind = K_RESP;
			OP_FRAME: dec.kind = K_FRAME;
			OP_CLEAR: dec.kind = K_CLEAR;
			default: dec.kind = K_NONE;
		endcase
	end

	assign in_ready = (used_q != 2'd2);
	assign cmd_valid = (used_q != 2'd0);
	assign cmd = entry_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			used_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				used_q <= used_q + 2'd1;
			end else if (pop && !push) begin
				used_q <= used_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

/* design/brfe_back.sv */
// Request engine: byte store, ring pointers, delimiter scan, byte pops and result register.
`timescale 1ns / 1ps
`default_nettype none
module brfe_back
	import brfe_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	input  wire cmd_t              cmd,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [BYTE_W-1:0]      out_byte,
	output logic                   byte_valid,
	output logic                   last,
	output logic                   ok,
	output logic [FILL_W-1:0]      fill_level
);
	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_SCAN_RD  = 5'b00010,
		S_SCAN_CHK = 5'b00100,
		S_POP_RD   = 5'b01000,
		S_POP_WR   = 5'b10000
	} back_state_t;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rdata_q;
	logic [PTR_W-1:0] rd_addr;

	back_state_t state_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [FILL_W-1:0] count_q;
	logic [FILL_W-1:0] remain_q;
	logic [FILL_W-1:0] idx_q;
	logic [PTR_W-1:0] scan_ptr_q;
	logic [BYTE_W-1:0] prev_q;
	cmd_kind_t kind_q;
	logic st_pend_q;
	logic st_ok_q;

	logic out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic byte_valid_q;
	logic last_q;
	logic ok_q;
	logic [FILL_W-1:0] fill_q;

	logic out_free;
	logic out_load;
	logic take;
	logic mem_we;
	logic idle_status;
	logic idle_ok;
	logic [FILL_W-1:0] idle_fill;
	logic idle_pop;
	logic [FILL_W-1:0] idle_n;
	logic idle_scan;
	logic [FILL_W-1:0] n_upto;
	logic scan_hit;
	logic scan_fail;

	assign out_free = !out_valid_q || out_ready;
	assign cmd_ready = (state_q == S_IDLE) && !st_pend_q;
	assign take = cmd_ready && cmd_valid;
	assign mem_we = take && (cmd.kind == K_WRITE) && (count_q != DEPTH_FILL);
	assign rd_addr = (state_q == S_SCAN_RD) ? scan_ptr_q : head_q;
	assign n_upto = (cmd.count == '0 || cmd.count > count_q) ? count_q : cmd.count;

	always_comb begin
		idle_status = 1'b0;
		idle_ok = 1'b0;
		idle_fill = count_q;
		idle_pop = 1'b0;
		idle_n = cmd.count;
		idle_scan = 1'b0;
		case (cmd.kind)
			K_WRITE: begin
				idle_status = 1'b1;
				idle_ok = (count_q != DEPTH_FILL);
				if (idle_ok) begin
					idle_fill = count_q + 1'b1;
				end
			end
			K_READ_UPTO: begin
				idle_n = n_upto;
				if (n_upto == '0) begin
					idle_status = 1'b1;
					idle_ok = 1'b1;
				end else begin
					idle_pop = 1'b1;
				end
			end
			K_READ_EXACT: begin
				if (cmd.count > count_q) begin
					idle_status = 1'b1;
				end else if (cmd.count == '0) begin
					idle_status = 1'b1;
					idle_ok = 1'b1;
				end else begin
					idle_pop = 1'b1;
				end
			end
			K_LINE, K_RESP, K_FRAME: begin
				if (count_q == '0) begin
					idle_status = 1'b1;
				end else begin
					idle_scan = 1'b1;
				end
			end
			K_CLEAR: begin
				idle_status = 1'b1;
				idle_ok = 1'b1;
				idle_fill = '0;
			end
			default: begin
				idle_status = 1'b1;
			end
		endcase
	end

	always_comb begin
		out_load = 1'b0;
		case (state_q)
			S_IDLE: out_load = out_free && (st_pend_q || (take && idle_status));
			S_POP_WR: out_load = out_free;
			default: out_load = 1'b0;
		endcase
	end

	always_comb begin
		scan_hit = 1'b0;
		scan_fail = (idx_q + 1'b1 == count_q);
		case (kind_q)
			K_LINE: scan_hit = (rdata_q == CH_LF) || (rdata_q == CH_CR);
			K_RESP: scan_hit = (idx_q != '0) && (prev_q == RESP_FIRST)
				&& (rdata_q == RESP_SECOND);
			K_FRAME: begin
				scan_hit = (idx_q != '0) && (rdata_q == FRAME_END);
				if (idx_q == '0 && rdata_q != FRAME_START) begin
					scan_fail = 1'b1;
				end
			end
			default: scan_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tail_q] <= cmd.data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			remain_q <= '0;
			idx_q <= '0;
			scan_ptr_q <= '0;
			prev_q <= '0;
			kind_q <= K_NONE;
			st_pend_q <= 1'b0;
			st_ok_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_byte_q <= '0;
			byte_valid_q <= 1'b0;
			last_q <= 1'b0;
			ok_q <= 1'b0;
			fill_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (st_pend_q) begin
						if (out_free) begin
							out_byte_q <= '0;
							byte_valid_q <= 1'b0;
							last_q <= 1'b1;
							ok_q <= st_ok_q;
							fill_q <= count_q;
							st_pend_q <= 1'b0;
						end
					end else if (take) begin
						kind_q <= cmd.kind;
						if (mem_we) begin
							tail_q <= next_ptr(tail_q);
							count_q <= count_q + 1'b1;
						end
						if (cmd.kind == K_CLEAR) begin
							head_q <= '0;
							tail_q <= '0;
							count_q <= '0;
						end
						if (idle_status) begin
							if (out_free) begin
								out_byte_q <= '0;
								byte_valid_q <= 1'b0;
								last_q <= 1'b1;
								ok_q <= idle_ok;
								fill_q <= idle_fill;
							end else begin
								st_pend_q <= 1'b1;
								st_ok_q <= idle_ok;
							end
						end
						if (idle_pop) begin
							remain_q <= idle_n;
							state_q <= S_POP_RD;
						end
						if (idle_scan) begin
							idx_q <= '0;
							scan_ptr_q <= head_q;
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					if (scan_hit) begin
						remain_q <= idx_q + 1'b1;
						state_q <= S_POP_RD;
					end else if (scan_fail) begin
						st_pend_q <= 1'b1;
						st_ok_q <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
						scan_ptr_q <= next_ptr(scan_ptr_q);
						prev_q <= rdata_q;
						state_q <= S_SCAN_RD;
					end
				end
				S_POP_RD: begin
					state_q <= S_POP_WR;
				end
				S_POP_WR: begin
					if (out_free) begin
						out_byte_q <= rdata_q;
						byte_valid_q <= 1'b1;
						last_q <= (remain_q == FILL_W'(1));
						ok_q <= 1'b1;
						fill_q <= count_q - 1'b1;
						head_q <= next_ptr(head_q);
						count_q <= count_q - 1'b1;
						remain_q <= remain_q - 1'b1;
						state_q <= (remain_q == FILL_W'(1)) ? S_IDLE : S_POP_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign last = last_q;
	assign ok = ok_q;
	assign fill_level = fill_q;
endmodule
`default_nettype wire

/* design/byte_ring_fifo_frame_extract.sv */
// Top level of the byte ring FIFO with delimiter framing.
`timescale 1ns / 1ps
`default_nettype none
// Requests enter a two-entry command queue, so the input side takes transfers, until the
// queue is full, while the engine works or a result waits at the output register. Writes,
// clears and requests that end in a single status result finish in the idle state, the
// status held while the output is busy. A pop reads the single-port store (S_POP_RD), then
// loads the output register (S_POP_WR). Line, response and frame requests scan from the
// head, a read and a check state per byte, on the same read port, then pop the matched
// bytes. A request's results come out in order, the final one with last set.
module byte_ring_fifo_frame_extract
	import brfe_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [OP_W-1:0]   op,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic [FILL_W-1:0] count,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [BYTE_W-1:0]      out_byte,
	output logic                   byte_valid,
	output logic                   last,
	output logic                   ok,
	output logic [FILL_W-1:0]      fill_level
);
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	brfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.data_byte (data_byte),
		.count     (count),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	brfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.last       (last),
		.ok         (ok),
		.fill_level (fill_level)
	);

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fill_level <= DEPTH_FILL)
		else $error("Reported fill level exceeds the store depth.");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> last && out_byte == '0)
		else $error("A status result is not the final one of its request.");

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
		else $error("A queued command changed before the engine took it.");

	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid |-> ok)
		else $error("A read byte was delivered without ok.");
`endif
endmodule
`default_nettype wire
